// ===== hdl/nla_pkg.sv =====
`default_nettype none
package nla_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
    localparam int POS_W     = 24;
    localparam int COLOR_W   = 2;
    localparam int MD_W      = 16;
    localparam int GATE_W    = 2 * MD_W;
    localparam int SQ_W      = 2 * POS_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int IDX_OUT_W = 8;
    localparam int CNT_OUT_W = 9;

    localparam logic [MD_W-1:0] MATCH_DISTANCE_RESET = 16'd256;

    typedef enum logic [1:0] {
        OUT_MATCH  = 2'd0,
        OUT_APPEND = 2'd1,
        OUT_DROP   = 2'd2
    } t_outcome;

    // One stored landmark.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } t_entry;

    // Travels alongside a map entry through the distance pipeline.
    typedef struct packed {
        logic [ADDR_W-1:0]  idx;
        logic [COLOR_W-1:0] color;
    } t_tag;

endpackage
`default_nettype wire

// ===== hdl/nla_dist.sv =====
`default_nettype none
module nla_dist
    import nla_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [POS_W-1:0]  i_px,
    input  wire logic [POS_W-1:0]  i_py,
    input  wire logic [POS_W-1:0]  i_mx,
    input  wire logic [POS_W-1:0]  i_my,
    input  wire t_tag              i_tag,
    output logic                   o_valid,
    output logic [DIST_W-1:0]      o_dist,
    output t_tag                   o_tag
);

    logic [POS_W:0]    w_dx;
    logic [POS_W:0]    w_dy;
    logic [POS_W-1:0]  w_ax;
    logic [POS_W-1:0]  w_ay;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [POS_W-1:0]  r_ax;
    logic [POS_W-1:0]  r_ay;
    logic [SQ_W-1:0]   r_sx;
    logic [SQ_W-1:0]   r_sy;
    logic [DIST_W-1:0] r_d;
    t_tag              r_tag1;
    t_tag              r_tag2;
    t_tag              r_tag3;

    // Differences are taken one bit wider so they cannot overflow; the
    // magnitude always fits back into the position width.
    assign w_dx = {i_px[POS_W-1], i_px} - {i_mx[POS_W-1], i_mx};
    assign w_dy = {i_py[POS_W-1], i_py} - {i_my[POS_W-1], i_my};
    assign w_ax = w_dx[POS_W] ? POS_W'(-w_dx) : w_dx[POS_W-1:0];
    assign w_ay = w_dy[POS_W] ? POS_W'(-w_dy) : w_dy[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_ax   <= w_ax;
        r_ay   <= w_ay;
        r_tag1 <= i_tag;
        r_sx   <= r_ax * r_ax;
        r_sy   <= r_ay * r_ay;
        r_tag2 <= r_tag1;
        r_d    <= {1'b0, r_sx} + {1'b0, r_sy};
        r_tag3 <= r_tag2;
    end

    assign o_valid = r_v3;
    assign o_dist  = r_d;
    assign o_tag   = r_tag3;

endmodule
`default_nettype wire

// ===== hdl/nearest_landmark_associate_top.sv =====
`default_nettype none
// Each landmark is handled alone: with N entries stored, the N map reads pass the three
// distance stages, and a decision state then loads the result register once it is free
// (an empty map goes straight to the decision). The block works on one item at a time:
// a new input transfer is accepted only in the idle state, after the result is loaded.
// Reset (synchronous, active low) empties the map and sets match_distance to 256;
// map memory contents are not cleared, since only entries below the count are read.
module nearest_landmark_associate_top
    import nla_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [MD_W-1:0]      i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [POS_W-1:0]     i_pos_x,
    input  wire logic [POS_W-1:0]     i_pos_y,
    input  wire logic [COLOR_W-1:0]   i_color,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_outcome,
    output logic [IDX_OUT_W-1:0]      o_entry_index,
    output logic [CNT_OUT_W-1:0]      o_entries_in_map
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state             r_state;
    logic [MD_W-1:0]    r_match_distance;
    logic [GATE_W-1:0]  r_gate;
    logic [CNT_W-1:0]   r_count;
    logic [POS_W-1:0]   r_px;
    logic [POS_W-1:0]   r_py;
    logic [COLOR_W-1:0] r_color;

    // Scan read side.
    logic [CNT_W-1:0]   r_rd_addr;
    logic               r_rd_valid;
    logic [ADDR_W-1:0]  r_rd_idx;
    t_entry             r_rd_data;

    // Best candidate so far.
    logic [DIST_W-1:0]  r_best_d;
    logic [ADDR_W-1:0]  r_best_idx;
    logic [COLOR_W-1:0] r_best_color;

    // Result register.
    logic               r_out_valid;
    t_outcome           r_outcome;
    logic [IDX_OUT_W-1:0] r_entry_index;
    logic [CNT_OUT_W-1:0] r_entries;

    t_entry             mem [MAP_DEPTH];

    logic               w_in_xfer;
    logic               w_rd_en;
    logic               w_finish;
    logic               w_matched;
    logic               w_full;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_waddr;
    t_entry             w_mem_wdata;
    t_tag               w_rd_tag;
    logic               w_d_valid;
    logic [DIST_W-1:0]  w_d;
    t_tag               w_d_tag;
    logic               w_last;
    logic               w_better;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // Issue one read per cycle until every stored entry has been requested.
    assign w_rd_en = (r_state == ST_SCAN) && (r_rd_addr < r_count);

    // The decision may only retire once the result register is free.
    assign w_finish = (r_state == ST_DECIDE) && (!r_out_valid || i_out_ready);

    assign w_matched = (r_count != '0) && (r_best_d < DIST_W'(r_gate));
    assign w_full    = (r_count == CNT_W'(MAP_DEPTH));

    // Write back: a match overwrites the position and keeps the color it read
    // during the scan; an append writes the whole entry at the end of the map.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_best_idx;
        w_mem_wdata = '{color: r_best_color, x: r_px, y: r_py};
        if (w_finish) begin
            if (w_matched) begin
                w_mem_we = 1'b1;
            end else if (!w_full) begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_count[ADDR_W-1:0];
                w_mem_wdata = '{color: r_color, x: r_px, y: r_py};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_rd_addr[ADDR_W-1:0]];
        end
    end

    assign w_rd_tag = '{idx: r_rd_idx, color: r_rd_data.color};

    nla_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_mx    (r_rd_data.x),
        .i_my    (r_rd_data.y),
        .i_tag   (w_rd_tag),
        .o_valid (w_d_valid),
        .o_dist  (w_d),
        .o_tag   (w_d_tag)
    );

    // The entry at index zero always seeds the search; afterwards only a
    // strictly smaller distance replaces it, so ties keep the lowest index.
    assign w_better = (w_d_tag.idx == '0) || (w_d < r_best_d);
    assign w_last   = (w_d_tag.idx == ADDR_W'(r_count - CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_match_distance <= MATCH_DISTANCE_RESET;
            r_count          <= '0;
            r_rd_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_match_distance <= i_cfg_wdata;
            end
            r_rd_valid <= w_rd_en;
            // A new result may be loaded in the same cycle the old one transfers out.
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= (r_count == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_d_valid && w_last) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_finish) begin
                        r_state <= ST_IDLE;
                        if (!w_matched && !w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end

        // Payload registers need no reset.
        if (w_in_xfer) begin
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_color   <= i_color;
            r_gate    <= r_match_distance * r_match_distance;
            r_rd_addr <= '0;
        end else if (w_rd_en) begin
            r_rd_addr <= r_rd_addr + CNT_W'(1);
        end
        r_rd_idx <= r_rd_addr[ADDR_W-1:0];

        if ((r_state == ST_SCAN) && w_d_valid && w_better) begin
            r_best_d     <= w_d;
            r_best_idx   <= w_d_tag.idx;
            r_best_color <= w_d_tag.color;
        end

        if (w_finish) begin
            if (w_matched) begin
                r_outcome     <= OUT_MATCH;
                r_entry_index <= IDX_OUT_W'(r_best_idx);
                r_entries     <= CNT_OUT_W'(r_count);
            end else if (!w_full) begin
                r_outcome     <= OUT_APPEND;
                r_entry_index <= IDX_OUT_W'(r_count);
                r_entries     <= CNT_OUT_W'(r_count + CNT_W'(1));
            end else begin
                r_outcome     <= OUT_DROP;
                r_entry_index <= '0;
                r_entries     <= CNT_OUT_W'(r_count);
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_entry_index    = r_entry_index;
    assign o_entries_in_map = r_entries;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
    import nla_pkg::*;

    // Random traffic runs in phases. Each phase starts with a new gating distance,
    // written while the block is drained.
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 102;
    localparam int MAX_GAP         = 17;
    // Long receiver hold-offs that back the block up into its input.
    localparam int HOLD_CYCLES     = 700;
    localparam int FIRST_HOLD_AT   = 30;
    localparam int SECOND_HOLD_AT  = 1000;
    localparam int SETTLE_CYCLES   = 8;
    // The tail wait covers one full-map scan.
    localparam int DRAIN_CYCLES    = 300;
    localparam int TIMEOUT_TIME    = 8_000_000;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } t_landmark;

    typedef struct {
        t_outcome               outcome;
        logic [IDX_OUT_W-1:0]   index;
        logic [CNT_OUT_W-1:0]   entries;
    } t_association;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [MD_W-1:0]       i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic [POS_W-1:0]      i_pos_x     = '0;
    logic [POS_W-1:0]      i_pos_y     = '0;
    logic [COLOR_W-1:0]    i_color     = '0;
    logic                  i_out_ready = 1'b0;
    wire                   o_in_ready;
    wire                   o_out_valid;
    wire [1:0]             o_outcome;
    wire [IDX_OUT_W-1:0]   o_entry_index;
    wire [CNT_OUT_W-1:0]   o_entries_in_map;

    // The testbench's own copy of the landmark positions and the gating register.
    // Positions are kept sign extended so that distances come out directly.
    longint            known_x [MAP_DEPTH];
    longint            known_y [MAP_DEPTH];
    int                known_count = 0;
    logic [MD_W-1:0]   match_gate  = MATCH_DISTANCE_RESET;

    t_landmark    pending_landmarks [$];
    t_association expected_associations [$];

    bit gaps_on            = 1'b1;
    int tx_gap             = 0;
    int rx_gap             = 0;
    int rx_hold_left       = 0;
    int holds_done         = 0;
    int landmarks_accepted = 0;
    int results_seen       = 0;
    int errors             = 0;

    nearest_landmark_associate_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_color          (i_color),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_entry_index    (o_entry_index),
        .o_entries_in_map (o_entries_in_map)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Associates one landmark with the map and returns what the block should report.
    // The nearest entry is found by squared distance, the lowest index winning a tie.
    // A match needs the squared distance to be strictly below the squared gate.
    function automatic t_association associate_landmark(t_landmark lm);
        longint       px;
        longint       py;
        longint       dx;
        longint       dy;
        longint       dist_sq;
        longint       best_dist;
        longint       gate_sq;
        int           best;
        t_association res;
        px = $signed(lm.x);
        py = $signed(lm.y);
        gate_sq = longint'(match_gate) * longint'(match_gate);
        best = 0;
        best_dist = 0;
        for (int i = 0; i < known_count; i++) begin
            dx = px - known_x[i];
            dy = py - known_y[i];
            dist_sq = dx * dx + dy * dy;
            if (i == 0 || dist_sq < best_dist) begin
                best_dist = dist_sq;
                best = i;
            end
        end
        if (known_count > 0 && best_dist < gate_sq) begin
            // The entry moves to the new position but keeps the color it was stored with.
            known_x[best] = px;
            known_y[best] = py;
            res.outcome = OUT_MATCH;
            res.index = IDX_OUT_W'(best);
        end else if (known_count < MAP_DEPTH) begin
            known_x[known_count] = px;
            known_y[known_count] = py;
            res.outcome = OUT_APPEND;
            res.index = IDX_OUT_W'(known_count);
            known_count++;
        end else begin
            res.outcome = OUT_DROP;
            res.index = '0;
        end
        res.entries = CNT_OUT_W'(known_count);
        return res;
    endfunction

    function automatic void note_failure(string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // Cycles that one side waits before its next transfer. At least a quarter of the draws are
    // zero so that back-to-back transfers stay common even while idling is on.
    function automatic int draw_gap();
        if (!gaps_on || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Sender. The expectation is worked out at the edge where the transfer happens,
    // so the map copy is always in step with what the block has accepted.
    always @(posedge i_clk) begin : landmark_driver
        int        gap_n;
        logic      took;
        t_landmark accepted_lm;
        t_landmark next_lm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                accepted_lm.x = i_pos_x;
                accepted_lm.y = i_pos_y;
                accepted_lm.color = i_color;
                expected_associations.insert(expected_associations.size(),
                                             associate_landmark(accepted_lm));
                landmarks_accepted++;
                gap_n = draw_gap();
            end else begin
                gap_n = (tx_gap > 0) ? tx_gap - 1 : 0;
            end
            // A landmark still on offer is held untouched until its transfer.
            if (took || !i_in_valid) begin
                if (gap_n == 0 && pending_landmarks.size() > 0) begin
                    next_lm = pending_landmarks.pop_front();
                    i_in_valid <= 1'b1;
                    i_pos_x <= next_lm.x;
                    i_pos_y <= next_lm.y;
                    i_color <= next_lm.color;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            tx_gap <= gap_n;
        end
    end

    // Two long hold-offs on the result side while landmarks keep coming. The block
    // works on one landmark at a time, so its input stalls soon after the hold starts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            holds_done <= 0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if ((holds_done == 0 && landmarks_accepted >= FIRST_HOLD_AT) ||
                     (holds_done == 1 && landmarks_accepted >= SECOND_HOLD_AT)) begin
            rx_hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver and checker. Every result transfer is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : association_monitor
        int           gap_n;
        t_association want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_associations.size() == 0) begin
                    note_failure($sformatf(
                        "result %0d arrived with nothing expected: outcome %0d index %0d entries %0d",
                        results_seen, o_outcome, o_entry_index, o_entries_in_map));
                end else begin
                    want = expected_associations.pop_front();
                    if (o_outcome !== want.outcome || o_entry_index !== want.index ||
                        o_entries_in_map !== want.entries) begin
                        note_failure($sformatf(
                            {"result %0d mismatch: expected outcome %0d index %0d entries %0d,",
                             " got outcome %0d index %0d entries %0d"},
                            results_seen, want.outcome, want.index, want.entries,
                            o_outcome, o_entry_index, o_entries_in_map));
                    end
                end
                gap_n = draw_gap();
            end else begin
                gap_n = (rx_gap > 0) ? rx_gap - 1 : 0;
            end
            rx_gap <= gap_n;
            i_out_ready <= (gap_n == 0) && (rx_hold_left == 0);
        end
    end

    task automatic queue_landmark(int x, int y, int c);
        t_landmark lm;
        lm.x = POS_W'(x);
        lm.y = POS_W'(y);
        lm.color = COLOR_W'(c);
        pending_landmarks.insert(pending_landmarks.size(), lm);
    endtask

    function automatic logic [POS_W-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0: begin
                return {1'b1, {(POS_W-1){1'b0}}};
            end
            1: begin
                return {1'b0, {(POS_W-1){1'b1}}};
            end
            2: begin
                return '0;
            end
            3: begin
                return '1;
            end
            default: begin
                return POS_W'($urandom);
            end
        endcase
    endfunction

    // Most random landmarks are sightings of something already in the map: close to an
    // entry, right on it, or right at the gate. The rest are fresh positions and corners.
    // Generation waits for room in the queue so that it looks at an up-to-date map.
    task automatic queue_random_landmark();
        t_landmark lm;
        int        g;
        int        kind;
        int        i;
        int        ox;
        int        oy;
        while (pending_landmarks.size() >= 4) begin
            @(posedge i_clk);
        end
        g = match_gate;
        lm.color = COLOR_W'($urandom_range(0, 3));
        kind = (known_count == 0) ? 70 : $urandom_range(0, 99);
        i = (known_count == 0) ? 0 : $urandom_range(0, known_count - 1);
        if (kind < 40) begin
            ox = int'($urandom_range(0, 2 * g)) - g;
            oy = int'($urandom_range(0, 2 * g)) - g;
            lm.x = POS_W'(known_x[i] + ox);
            lm.y = POS_W'(known_y[i] + oy);
        end else if (kind < 55) begin
            lm.x = POS_W'(known_x[i]);
            lm.y = POS_W'(known_y[i]);
        end else if (kind < 65) begin
            // Exactly at the gate does not match; one unit inside it does.
            ox = g - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) begin
                ox = -ox;
            end
            if ($urandom_range(0, 1)) begin
                lm.x = POS_W'(known_x[i] + ox);
                lm.y = POS_W'(known_y[i]);
            end else begin
                lm.x = POS_W'(known_x[i]);
                lm.y = POS_W'(known_y[i] + ox);
            end
        end else if (kind < 90) begin
            lm.x = POS_W'($urandom);
            lm.y = POS_W'($urandom);
        end else begin
            lm.x = pick_corner();
            lm.y = pick_corner();
        end
        pending_landmarks.insert(pending_landmarks.size(), lm);
    endtask

    // Waits until every landmark has been transferred in and every result has come out.
    task automatic wait_drained();
        while (pending_landmarks.size() != 0 || i_in_valid ||
               expected_associations.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gate(logic [MD_W-1:0] g);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        match_gate = g;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset gate of 256. The first landmark lands in an empty
        // map. Then come an exact repeat, a match just inside the gate, a miss exactly at
        // the gate, the four coordinate corners, and near hits on a corner and on entry 0.
        queue_landmark(0, 0, 0);
        queue_landmark(0, 0, 1);
        queue_landmark(255, 0, 2);
        queue_landmark(511, 0, 3);
        queue_landmark(-8388608, -8388608, 3);
        queue_landmark(8388607, 8388607, 2);
        queue_landmark(8388607, -8388608, 1);
        queue_landmark(-8388608, 8388607, 0);
        queue_landmark(-8388607, -8388608, 1);
        queue_landmark(0, -1, 0);
        wait_drained();

        // With a zero gate nothing matches, not even a landmark sitting on an entry.
        set_gate('0);
        queue_landmark(10000, 0, 1);
        queue_landmark(10100, 0, 2);
        queue_landmark(10000, 0, 3);
        wait_drained();

        // Three entries lie equally far from this point and the lowest index has to win.
        // The next landmark then sits exactly on the duplicate entry.
        set_gate(MATCH_DISTANCE_RESET);
        queue_landmark(10050, 0, 0);
        queue_landmark(10000, 0, 2);
        wait_drained();

        // Widest gate: a landmark just short of 65535 away still matches.
        set_gate('1);
        queue_landmark(-8388607 + 65534, -8388608, 2);
        queue_landmark(100000, 3000000, 2);
        queue_landmark(-1, -1, 3);
        wait_drained();

        // Random phases. Zero and small gates fill the map quickly, after which the
        // block spends most of its time on full-map scans that update or drop.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gaps_on = (p % 4 != 3);
            case (p % 6)
                0: begin
                    set_gate(MD_W'($urandom_range(0, 65535)));
                end
                1: begin
                    set_gate('0);
                end
                2: begin
                    set_gate('1);
                end
                3: begin
                    set_gate(MD_W'($urandom_range(1, 2000)));
                end
                4: begin
                    set_gate(MATCH_DISTANCE_RESET);
                end
                default: begin
                    set_gate(MD_W'(1));
                end
            endcase
            repeat (ITEMS_PER_PHASE) queue_random_landmark();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_associations.size() == 0) begin
            $display("nearest_landmark_associate_top regression: pass");
        end else begin
            $display("nearest_landmark_associate_top regression: fail");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_TIME;
        $display("nearest_landmark_associate_top regression: fail");
        $finish;
    end

endmodule

// ===== nearest_landmark_associate_top.f =====
hdl/nla_pkg.sv
hdl/nla_dist.sv
hdl/nearest_landmark_associate_top.sv
test/tb_top.sv
